// File: rtl/pfd_pkg.sv
package pfd_pkg;

  localparam logic [4:0] FULL_CELLS  = 5'd25;
  localparam logic [4:0] IDX_I       = 5'd8;
  localparam logic [4:0] IDX_J       = 5'd9;
  localparam logic [4:0] LAST_LETTER = 5'd25;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_Z  = 8'h5a;
  localparam logic [7:0] CH_LOWER_A  = 8'h61;
  localparam logic [7:0] CH_LOWER_Z  = 8'h7a;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  typedef enum logic [2:0] {
    REQ_CLEAR  = 3'd0,
    REQ_KEY    = 3'd1,
    REQ_FINISH = 3'd2,
    REQ_CIPHER = 3'd3,
    REQ_FLUSH  = 3'd4
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_RD_A,
    ST_RD_B,
    ST_MAP,
    ST_KS_A,
    ST_KS_B,
    ST_KS_C,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic       en;
    logic [4:0] slot;
    logic [4:0] letter;
  } pfd_wr_t;

  function automatic logic [4:0] fold_j(input logic [4:0] idx);
    return (idx == IDX_J) ? IDX_I : idx;
  endfunction

  // Row of a cell in 0..24, taken as (p * 13) >> 6.
  function automatic logic [2:0] row_of(input logic [4:0] p);
    logic [8:0] t;
    t = 9'(p) * 9'd13;
    return t[8:6];
  endfunction

  function automatic logic [2:0] col_of(input logic [4:0] p);
    logic [2:0] r;
    logic [4:0] base;
    r    = row_of(p);
    base = {r, 2'b00} + {2'b00, r};
    return 3'(p - base);
  endfunction

  function automatic logic [4:0] cell_of(input logic [2:0] r, input logic [2:0] c);
    return {r, 2'b00} + {2'b00, r} + {2'b00, c};
  endfunction

endpackage

// File: rtl/pfd_store.sv
module pfd_store import pfd_pkg::*; (
  input  logic       clk,
  input  pfd_wr_t    wr,
  input  logic [4:0] lp_raddr,
  output logic [4:0] lp_rdata,
  input  logic [4:0] ks_raddr,
  output logic [4:0] ks_rdata
);

  logic [4:0] key_square_mem [0:24];
  logic [4:0] letter_pos_mem [0:25];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      key_square_mem[wr.slot]   <= wr.letter;
      letter_pos_mem[wr.letter] <= wr.slot;
    end
    lp_rdata <= letter_pos_mem[lp_raddr];
    ks_rdata <= key_square_mem[ks_raddr];
  end

endmodule

// File: rtl/pfd_cell_map.sv
module pfd_cell_map import pfd_pkg::*; (
  input  logic [4:0] pa,
  input  logic [4:0] pb,
  output logic [4:0] oa,
  output logic [4:0] ob
);

  logic [2:0] ra, ca, rb, cb;

  always_comb begin
    ra = row_of(pa);
    ca = col_of(pa);
    rb = row_of(pb);
    cb = col_of(pb);
    if (ra == rb) begin
      oa = cell_of(ra, (ca == 3'd0) ? 3'd4 : ca - 3'd1);
      ob = cell_of(rb, (cb == 3'd0) ? 3'd4 : cb - 3'd1);
    end else if (ca == cb) begin
      oa = cell_of((ra == 3'd0) ? 3'd4 : ra - 3'd1, ca);
      ob = cell_of((rb == 3'd0) ? 3'd4 : rb - 3'd1, cb);
    end else begin
      oa = cell_of(ra, cb);
      ob = cell_of(rb, ca);
    end
  end

endmodule

// File: rtl/playfair_decrypt_engine_core.sv
// Clear, keyword and unused requests complete in IDLE on acceptance; finish walks the 26 letters.
// A cipher letter that completes a pair on a full square steps through RD_A, RD_B, MAP,
// KS_A, KS_B and KS_C, reading the position and key-square memories; its two results
// leave from a buffer. Other results go from the staging registers into the buffer in LOAD.
// An item with results waits in LOAD for an empty buffer, so output stalls hold it there.
// Reset (synchronous, rst_n low) empties the square, drops any pending letter and the buffer.
module playfair_decrypt_engine_core import pfd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_char
  input  logic [2:0] in_tuser,   // [2:0] req_type
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic       out_tuser,  // [0] bad_char
  output logic       out_tlast
);

  state_t      state_r, state_nxt;
  logic [4:0]  fill_r, fill_nxt;
  logic [4:0]  fi_r, fi_nxt;
  logic [25:0] used_r, used_nxt;
  logic [7:0]  pend_char_r, pend_char_nxt;
  logic        pend_vld_r, pend_vld_nxt;
  logic [4:0]  a_r, a_nxt, b_r, b_nxt;
  logic [4:0]  pa_r, pa_nxt, oa_r, oa_nxt, ob_r, ob_nxt;
  logic [7:0]  stg_char0_r, stg_char0_nxt, stg_char1_r, stg_char1_nxt;
  logic        stg_bad0_r, stg_bad0_nxt, stg_two_r, stg_two_nxt;

  logic [7:0]  buf_char_r [2];
  logic [7:0]  buf_char_nxt [2];
  logic        buf_bad_r [2];
  logic        buf_bad_nxt [2];
  logic        buf_last_r [2];
  logic        buf_last_nxt [2];
  logic [1:0]  buf_cnt_r, buf_cnt_nxt;

  logic        place_try, place_ok, buf_load, pop;
  logic [4:0]  place_idx, lp_raddr, ks_raddr, lp_rdata, ks_rdata, map_oa, map_ob;
  logic [7:0]  upc;
  pfd_wr_t     wr;

  pfd_store u_store (
    .clk      (clk),
    .wr       (wr),
    .lp_raddr (lp_raddr),
    .lp_rdata (lp_rdata),
    .ks_raddr (ks_raddr),
    .ks_rdata (ks_rdata)
  );

  pfd_cell_map u_map (
    .pa (pa_r),
    .pb (lp_rdata),
    .oa (map_oa),
    .ob (map_ob)
  );

  assign place_ok  = place_try && (fill_r != FULL_CELLS) && !used_r[place_idx];
  assign wr.en     = place_ok;
  assign wr.slot   = fill_r;
  assign wr.letter = place_idx;

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    fi_nxt        = fi_r;
    used_nxt      = used_r;
    pend_char_nxt = pend_char_r;
    pend_vld_nxt  = pend_vld_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    pa_nxt        = pa_r;
    oa_nxt        = oa_r;
    ob_nxt        = ob_r;
    stg_char0_nxt = stg_char0_r;
    stg_char1_nxt = stg_char1_r;
    stg_bad0_nxt  = stg_bad0_r;
    stg_two_nxt   = stg_two_r;
    in_tready     = 1'b0;
    place_try     = 1'b0;
    place_idx     = fi_r;
    lp_raddr      = a_r;
    ks_raddr      = oa_r;
    buf_load      = 1'b0;
    upc           = in_tdata;

    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          case (req_t'(in_tuser))
            REQ_CLEAR: begin
              used_nxt      = '0;
              fill_nxt      = '0;
              pend_char_nxt = '0;
              pend_vld_nxt  = 1'b0;
            end
            REQ_KEY: begin
              if (in_tdata >= CH_LOWER_A && in_tdata <= CH_LOWER_Z) begin
                upc = in_tdata - CASE_OFFSET;
              end
              if (upc >= CH_UPPER_A && upc <= CH_UPPER_Z) begin
                place_try = 1'b1;
                place_idx = fold_j(5'(upc - CH_UPPER_A));
              end
            end
            REQ_FINISH: begin
              fi_nxt    = '0;
              state_nxt = ST_FILL;
            end
            REQ_CIPHER: begin
              if (in_tdata < CH_UPPER_A || in_tdata > CH_UPPER_Z) begin
                stg_char0_nxt = in_tdata;
                stg_bad0_nxt  = 1'b1;
                stg_two_nxt   = 1'b0;
                state_nxt     = ST_LOAD;
              end else if (!pend_vld_r) begin
                pend_char_nxt = in_tdata;
                pend_vld_nxt  = 1'b1;
              end else begin
                pend_vld_nxt = 1'b0;
                if (fill_r != FULL_CELLS) begin
                  stg_char0_nxt = pend_char_r;
                  stg_char1_nxt = in_tdata;
                  stg_bad0_nxt  = 1'b0;
                  stg_two_nxt   = 1'b1;
                  state_nxt     = ST_LOAD;
                end else begin
                  a_nxt     = fold_j(5'(pend_char_r - CH_UPPER_A));
                  b_nxt     = fold_j(5'(in_tdata - CH_UPPER_A));
                  state_nxt = ST_RD_A;
                end
              end
            end
            REQ_FLUSH: begin
              if (pend_vld_r) begin
                pend_vld_nxt  = 1'b0;
                stg_char0_nxt = pend_char_r;
                stg_bad0_nxt  = 1'b0;
                stg_two_nxt   = 1'b0;
                state_nxt     = ST_LOAD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_FILL: begin
        place_try = (fi_r != IDX_J);
        place_idx = fi_r;
        if (fi_r == LAST_LETTER) begin
          state_nxt = ST_IDLE;
        end else begin
          fi_nxt = fi_r + 5'd1;
        end
      end
      ST_RD_A: begin
        lp_raddr  = a_r;
        state_nxt = ST_RD_B;
      end
      ST_RD_B: begin
        lp_raddr  = b_r;
        pa_nxt    = lp_rdata;
        state_nxt = ST_MAP;
      end
      ST_MAP: begin
        oa_nxt    = map_oa;
        ob_nxt    = map_ob;
        state_nxt = ST_KS_A;
      end
      ST_KS_A: begin
        ks_raddr  = oa_r;
        state_nxt = ST_KS_B;
      end
      ST_KS_B: begin
        ks_raddr      = ob_r;
        stg_char0_nxt = CH_UPPER_A + 8'(ks_rdata);
        stg_bad0_nxt  = 1'b0;
        state_nxt     = ST_KS_C;
      end
      ST_KS_C: begin
        stg_char1_nxt = CH_UPPER_A + 8'(ks_rdata);
        stg_two_nxt   = 1'b1;
        state_nxt     = ST_LOAD;
      end
      ST_LOAD: begin
        if (buf_cnt_r == 2'd0) begin
          buf_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (place_ok) begin
      used_nxt[place_idx] = 1'b1;
      fill_nxt            = fill_r + 5'd1;
    end
  end

  assign out_tvalid = (buf_cnt_r != 2'd0);
  assign out_tdata  = buf_char_r[0];
  assign out_tuser  = buf_bad_r[0];
  assign out_tlast  = buf_last_r[0];
  assign pop        = out_tvalid && out_tready;

  always_comb begin
    buf_char_nxt = buf_char_r;
    buf_bad_nxt  = buf_bad_r;
    buf_last_nxt = buf_last_r;
    buf_cnt_nxt  = buf_cnt_r;
    if (buf_load) begin
      buf_char_nxt[0] = stg_char0_r;
      buf_bad_nxt[0]  = stg_bad0_r;
      buf_last_nxt[0] = !stg_two_r;
      buf_char_nxt[1] = stg_char1_r;
      buf_bad_nxt[1]  = 1'b0;
      buf_last_nxt[1] = 1'b1;
      buf_cnt_nxt     = stg_two_r ? 2'd2 : 2'd1;
    end else if (pop) begin
      buf_char_nxt[0] = buf_char_r[1];
      buf_bad_nxt[0]  = buf_bad_r[1];
      buf_last_nxt[0] = buf_last_r[1];
      buf_cnt_nxt     = buf_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      fi_r        <= '0;
      used_r      <= '0;
      pend_char_r <= '0;
      pend_vld_r  <= 1'b0;
      buf_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      fi_r        <= fi_nxt;
      used_r      <= used_nxt;
      pend_char_r <= pend_char_nxt;
      pend_vld_r  <= pend_vld_nxt;
      buf_cnt_r   <= buf_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    pa_r         <= pa_nxt;
    oa_r         <= oa_nxt;
    ob_r         <= ob_nxt;
    stg_char0_r  <= stg_char0_nxt;
    stg_char1_r  <= stg_char1_nxt;
    stg_bad0_r   <= stg_bad0_nxt;
    stg_two_r    <= stg_two_nxt;
    buf_char_r   <= buf_char_nxt;
    buf_bad_r    <= buf_bad_nxt;
    buf_last_r   <= buf_last_nxt;
  end

endmodule
